// File: hdl/khea_pkg.sv
// Shared types and constants for the keyed hit energy accumulator.
package khea_pkg;

   localparam int SCINT_W    = 8;
   localparam int PARTICLE_W = 32;
   localparam int TRACK_W    = 24;
   localparam int ENERGY_W   = 32;
   localparam int SUM_W      = 40;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int KEY_W      = SCINT_W + PARTICLE_W + TRACK_W;
   localparam int ENTRY_W    = KEY_W + SUM_W;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 120;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic [STATUS_W-1:0] HIT_ADDED   = 2'd0;
   localparam logic [STATUS_W-1:0] HIT_NEW     = 2'd1;
   localparam logic [STATUS_W-1:0] HIT_IGNORED = 2'd2;
   localparam logic [STATUS_W-1:0] HIT_DROPPED = 2'd3;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_DUMP  = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   typedef enum logic [2:0] {
      EMIT_NONE    = 3'd0,
      EMIT_ADDED   = 3'd1,
      EMIT_NEW     = 3'd2,
      EMIT_IGNORED = 3'd3,
      EMIT_DROPPED = 3'd4,
      EMIT_EMPTY   = 3'd5,
      EMIT_DUMP    = 3'd6
   } emit_type;

   typedef struct packed {
      logic     load;
      logic     match_cap;
      logic     rd_match;
      logic     dump_rd;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic is_dump;
      logic hit_valid;
      logic any_match;
      logic full;
      logic fill_zero;
      logic dump_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic                   kind;
      logic [STATUS_W-1:0]    hit_status;
      logic [SCINT_W-1:0]     entry_scint;
      logic [PARTICLE_W-1:0]  entry_particle;
      logic [TRACK_W-1:0]     entry_track;
      logic [SUM_W-1:0]       energy_sum;
      logic [COUNT_W-1:0]     entry_count;
      logic                   table_empty;
      logic                   last;
   } result_type;

endpackage

// File: hdl/khea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module khea_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [AW-1:0]         waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  re,
   input  logic [AW-1:0]         raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/khea_ctrl.sv
// Controller state machine: sequences search, update, append and dump.
module khea_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  khea_pkg::status_type  status,
   output khea_pkg::cmd_type     cmd
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_CHECK    = 10'b0000000010,
      ST_SEARCH   = 10'b0000000100,
      ST_ADD      = 10'b0000001000,
      ST_NEW      = 10'b0000010000,
      ST_IGNORE   = 10'b0000100000,
      ST_DROP     = 10'b0001000000,
      ST_EMPTY    = 10'b0010000000,
      ST_DUMP_RD  = 10'b0100000000,
      ST_DUMP_OUT = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.match_cap = 1'b0;
      cmd.rd_match  = 1'b0;
      cmd.dump_rd   = 1'b0;
      cmd.emit      = khea_pkg::EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.match_cap = 1'b1;
            if (status.is_dump) begin
               state_in = status.fill_zero ? ST_EMPTY : ST_DUMP_RD;
            end else if (!status.hit_valid) begin
               state_in = ST_IGNORE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.any_match) begin
               cmd.rd_match = 1'b1;
               state_in     = ST_ADD;
            end else if (status.full) begin
               state_in = ST_DROP;
            end else begin
               state_in = ST_NEW;
            end
         end
         ST_ADD: begin
            if (status.out_free) begin
               cmd.emit = khea_pkg::EMIT_ADDED;
               state_in = ST_IDLE;
            end
         end
         ST_NEW: begin
            if (status.out_free) begin
               cmd.emit = khea_pkg::EMIT_NEW;
               state_in = ST_IDLE;
            end
         end
         ST_IGNORE: begin
            if (status.out_free) begin
               cmd.emit = khea_pkg::EMIT_IGNORED;
               state_in = ST_IDLE;
            end
         end
         ST_DROP: begin
            if (status.out_free) begin
               cmd.emit = khea_pkg::EMIT_DROPPED;
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.emit = khea_pkg::EMIT_EMPTY;
               state_in = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            cmd.dump_rd = 1'b1;
            state_in    = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (status.out_free) begin
               cmd.emit = khea_pkg::EMIT_DUMP;
               state_in = status.dump_last ? ST_IDLE : ST_DUMP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/khea_dpath.sv
// Datapath: key cells with parallel match, entry RAM, saturating adder, result register.
module khea_dpath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [khea_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [0:0]                           req_tuser,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output khea_pkg::result_type                 rsp_result,
   input  khea_pkg::cmd_type                    cmd,
   output khea_pkg::status_type                 status
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // latched request
   logic                                op_ff;
   logic [khea_pkg::SCINT_W-1:0]        scint_ff;
   logic [khea_pkg::PARTICLE_W-1:0]     particle_ff;
   logic [khea_pkg::TRACK_W-1:0]        track_ff;
   logic [khea_pkg::ENERGY_W-1:0]       energy_ff;
   logic [khea_pkg::KEY_W-1:0]          key;

   logic [khea_pkg::KEY_W-1:0]          key_cells_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]              match_in;
   logic [TABLE_DEPTH-1:0]              match_ff;
   logic [IDX_W-1:0]                    match_idx;
   logic [IDX_W-1:0]                    idx_ff;
   logic [IDX_W-1:0]                    dump_idx_ff;
   logic [IDX_W-1:0]                    fill_idx;
   logic [CNT_W-1:0]                    fill_ff;
   logic [CNT_W-1:0]                    fill_inc;

   logic                                ram_we;
   logic [IDX_W-1:0]                    ram_waddr;
   logic [khea_pkg::ENTRY_W-1:0]        ram_wdata;
   logic                                ram_re;
   logic [IDX_W-1:0]                    ram_raddr;
   logic [khea_pkg::ENTRY_W-1:0]        ram_rdata;
   logic [khea_pkg::SUM_W-1:0]          rd_sum;
   logic [khea_pkg::SUM_W:0]            sum_wide;
   logic [khea_pkg::SUM_W-1:0]          sum_sat;
   logic [khea_pkg::SUM_W-1:0]          energy_ext;

   khea_pkg::result_type                rsp_ff;
   khea_pkg::result_type                rsp_in;
   logic                                rsp_valid_ff;

   assign key      = {scint_ff, particle_ff, track_ff};
   assign fill_idx = fill_ff[IDX_W-1:0];
   assign fill_inc = fill_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_tuser[0];
         scint_ff    <= req_tdata[7:0];
         particle_ff <= req_tdata[39:8];
         track_ff    <= req_tdata[63:40];
         energy_ff   <= req_tdata[95:64];
      end
   end

   // only entries below the fill count take part in the match
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_in[i] = (CNT_W'(i) < fill_ff) && (key_cells_ff[i] == key);
      end
   end

   always_comb begin
      match_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (match_ff[i]) begin
            match_idx = match_idx | IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match_cap) begin
         match_ff <= match_in;
      end
      if (cmd.rd_match) begin
         idx_ff <= match_idx;
      end
      if (cmd.emit == khea_pkg::EMIT_NEW) begin
         key_cells_ff[fill_idx] <= key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         dump_idx_ff <= '0;
      end else begin
         if (cmd.emit == khea_pkg::EMIT_NEW) begin
            fill_ff <= fill_inc;
         end
         if (cmd.emit == khea_pkg::EMIT_DUMP) begin
            if (status.dump_last) begin
               fill_ff     <= '0;
               dump_idx_ff <= '0;
            end else begin
               dump_idx_ff <= dump_idx_ff + IDX_W'(1);
            end
         end
      end
   end

   assign rd_sum     = ram_rdata[khea_pkg::SUM_W-1:0];
   assign energy_ext = khea_pkg::SUM_W'(energy_ff);
   assign sum_wide   = {1'b0, rd_sum} + {1'b0, energy_ext};
   assign sum_sat    = sum_wide[khea_pkg::SUM_W] ? khea_pkg::SUM_MAX
                                                 : sum_wide[khea_pkg::SUM_W-1:0];

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = fill_idx;
      ram_wdata = {key, energy_ext};
      case (cmd.emit)
         khea_pkg::EMIT_ADDED: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = {key, sum_sat};
         end
         khea_pkg::EMIT_NEW: begin
            ram_we = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   assign ram_re    = cmd.rd_match | cmd.dump_rd;
   assign ram_raddr = cmd.dump_rd ? dump_idx_ff : match_idx;

   khea_ram #(
      .WIDTH(khea_pkg::ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_entry_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      rsp_in                = '0;
      rsp_in.kind           = khea_pkg::KIND_STATUS;
      rsp_in.last           = 1'b1;
      rsp_in.entry_count    = khea_pkg::COUNT_W'(fill_ff);
      case (cmd.emit)
         khea_pkg::EMIT_ADDED: begin
            rsp_in.hit_status     = khea_pkg::HIT_ADDED;
            rsp_in.entry_scint    = scint_ff;
            rsp_in.entry_particle = particle_ff;
            rsp_in.entry_track    = track_ff;
            rsp_in.energy_sum     = sum_sat;
         end
         khea_pkg::EMIT_NEW: begin
            rsp_in.hit_status     = khea_pkg::HIT_NEW;
            rsp_in.entry_scint    = scint_ff;
            rsp_in.entry_particle = particle_ff;
            rsp_in.entry_track    = track_ff;
            rsp_in.energy_sum     = energy_ext;
            rsp_in.entry_count    = khea_pkg::COUNT_W'(fill_inc);
         end
         khea_pkg::EMIT_IGNORED: begin
            rsp_in.hit_status = khea_pkg::HIT_IGNORED;
         end
         khea_pkg::EMIT_DROPPED: begin
            rsp_in.hit_status = khea_pkg::HIT_DROPPED;
         end
         khea_pkg::EMIT_EMPTY: begin
            rsp_in.kind        = khea_pkg::KIND_ENTRY;
            rsp_in.entry_count = '0;
            rsp_in.table_empty = 1'b1;
         end
         khea_pkg::EMIT_DUMP: begin
            rsp_in.kind           = khea_pkg::KIND_ENTRY;
            {rsp_in.entry_scint, rsp_in.entry_particle, rsp_in.entry_track,
             rsp_in.energy_sum}   = ram_rdata;
            rsp_in.last           = status.dump_last;
         end
         default: begin
            rsp_in.last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != khea_pkg::EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != khea_pkg::EMIT_NONE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   assign status.is_dump   = (op_ff == khea_pkg::OP_DUMP);
   assign status.hit_valid = !scint_ff[khea_pkg::SCINT_W-1] && (scint_ff != '0);
   assign status.any_match = |match_ff;
   assign status.full      = (fill_ff == CNT_W'(TABLE_DEPTH));
   assign status.fill_zero = (fill_ff == '0);
   assign status.dump_last = ((CNT_W'(dump_idx_ff) + CNT_W'(1)) == fill_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

// File: hdl/keyed_hit_energy_accumulator.sv
// Top level of the keyed hit energy accumulator.
//
// Requests arrive on req_*: req_tuser selects accumulate (0) or dump (1),
// req_tdata carries the hit. An accumulate request sums the energy into the
// entry whose (scintillator, particle, track) key matches, appends a new entry,
// or reports the hit as ignored (scintillator <= 0) or dropped (table full).
// A dump request streams every entry in insertion order on rsp_*, rsp_tlast
// on the final one, then empties the table; an empty table gives one result.
// Every request gets at least one result; rsp_tlast closes its results.
// Flow: an added, new or dropped hit passes the check and search states and
// then its result state on the way to the result register (parallel key
// compare against all entry cells, index encode plus entry RAM read, add and
// write back). An ignored hit and an empty dump skip the search state. A dump
// reads each entry with one registered RAM read, then emits it. req_tready is
// high only in idle, so the next request can be taken no earlier than the
// cycle after the previous result is loaded.
// A result waits in the output register while rsp_tready is low; the block
// stalls at its next result until the register is taken.
// Reset empties the table (fill count to zero) and drops any pending result.
module keyed_hit_energy_accumulator #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // scint_number[7:0], particle_code[39:8], track_number[63:40],
   // energy_deposit[95:64]
   input  logic [95:0]   req_tdata,
   // op[0]
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // hit_status[1:0], entry_scint[9:2], entry_particle[41:10],
   // entry_track[65:42], energy_sum[105:66], entry_count[112:106],
   // table_empty[113], zero[119:114]
   output logic [119:0]  rsp_tdata,
   // kind[0]
   output logic [0:0]    rsp_tuser,
   output logic          rsp_tlast
);

   khea_pkg::cmd_type    cmd;
   khea_pkg::status_type status;
   khea_pkg::result_type result;

   khea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   khea_dpath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_result(result),
      .cmd       (cmd),
      .status    (status)
   );

   assign rsp_tdata = {6'b0, result.table_empty, result.entry_count, result.energy_sum,
                       result.entry_track, result.entry_particle, result.entry_scint,
                       result.hit_status};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

   // block turns busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   // never overwrite a result that has not been taken
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit != khea_pkg::EMIT_NONE |-> status.out_free)
      else $error("result register overwritten");

   // final dumped entry leaves the table empty
   a_dump_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit == khea_pkg::EMIT_DUMP && status.dump_last |=> status.fill_zero)
      else $error("table not cleared after dump");

   // a matched entry is read only on a found key in an accumulate request
   a_add_needs_match: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_match |-> status.any_match && !status.is_dump)
      else $error("entry read without a key match");

endmodule
